@@ rtl/mfd_pkg.sv @@
// ----------------------------------------------------------------------------
// Manchester frame decoder package
// Shared widths, codes and control structures for the frame decoder.
// ----------------------------------------------------------------------------
package mfd_pkg;

   // Default depth of the interval store
   localparam int MAX_EDGES_DEF = 512;

   // Frame layout
   localparam int FRAME_BYTES = 17;
   localparam int NUM_TEMPS   = 6;
   localparam int NUM_RELAYS  = 4;
   localparam int FIRST_RELAY = 13;
   localparam int LEN_LO      = (FRAME_BYTES - 1) * 8 + 1;
   localparam int LEN_HI      = FRAME_BYTES * 8;

   // Field widths
   localparam int INTERVAL_W  = 16;
   localparam int MIN_EDGES_W = 10;
   localparam int ID_W        = 8;
   localparam int STATUS_W    = 3;
   localparam int TEMP_W      = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 10;

   // Reset values of the configuration registers
   localparam logic [MIN_EDGES_W-1:0] MIN_EDGES_RST   = 10'd100;
   localparam logic [ID_W-1:0]        EXPECTED_ID_RST = 8'h20;

   typedef logic [INTERVAL_W-1:0]  interval_type;
   typedef logic [INTERVAL_W:0]    sum_type;
   typedef logic [MIN_EDGES_W-1:0] min_edges_type;
   typedef logic [ID_W-1:0]        id_type;
   typedef logic signed [TEMP_W-1:0] temp_type;
   typedef logic [CSR_IDX_W-1:0]   csr_idx_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;
   typedef logic [FRAME_BYTES-1:0][7:0] frame_bytes_type;

   // Item kinds
   localparam logic KIND_EDGE    = 1'b0;
   localparam logic KIND_TIMEOUT = 1'b1;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MIN_EDGES   = 2'd0,
      REG_EXPECTED_ID = 2'd1
   } reg_idx_type;

   // Frame status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_TOO_FEW  = 3'd1,
      ST_BAD_PAIR = 3'd2,
      ST_BAD_LEN  = 3'd3,
      ST_BAD_ID   = 3'd4
   } status_type;

   // Control from the frame collector to the decode sequencer
   typedef struct packed {
      logic start;
      logic ack;
   } dec_ctrl_type;

   // Status from the decode sequencer back to the frame collector
   typedef struct packed {
      logic       done;
      status_type status;
   } dec_stat_type;

endpackage

@@ rtl/mfd_if.sv @@
// ----------------------------------------------------------------------------
// Manchester frame decoder channel interfaces
// Edge item channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface mfd_req_if;
   import mfd_pkg::*;

   logic         valid;
   logic         ready;
   logic         kind;
   interval_type interval;

   modport source (output valid, kind, interval, input ready);
   modport sink   (input valid, kind, interval, output ready);
endinterface

interface mfd_rsp_if;
   import mfd_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   temp_type              temp_a;
   temp_type              temp_b;
   temp_type              temp_c;
   temp_type              temp_d;
   temp_type              temp_e;
   temp_type              temp_f;
   logic [NUM_RELAYS-1:0] relay_mask;

   modport source (output valid, status, temp_a, temp_b, temp_c, temp_d, temp_e, temp_f,
                   relay_mask, input ready);
   modport sink   (input valid, status, temp_a, temp_b, temp_c, temp_d, temp_e, temp_f,
                   relay_mask, output ready);
endinterface

interface mfd_csr_if;
   import mfd_pkg::*;

   logic         valid;
   logic         ready;
   csr_idx_type  index;
   csr_data_type data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/mfd_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mfd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/mfd_decode.sv @@
// ----------------------------------------------------------------------------
// Manchester frame decode sequencer
// Walks the interval store one entry a cycle, classes pairs and packs bytes.
// ----------------------------------------------------------------------------
module mfd_decode #(
   parameter int MAX_EDGES = mfd_pkg::MAX_EDGES_DEF,
   localparam int ADDR_W = $clog2(MAX_EDGES),
   localparam int CNT_W  = $clog2(MAX_EDGES + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mfd_pkg::dec_ctrl_type   ctrl,
   output mfd_pkg::dec_stat_type   stat,
   input  logic [CNT_W-1:0]        edge_count,
   input  mfd_pkg::min_edges_type  min_edges,
   input  mfd_pkg::id_type         expected_id,
   input  mfd_pkg::sum_type        sum,
   output logic                    rd_en,
   output logic [ADDR_W-1:0]       rd_addr,
   input  mfd_pkg::interval_type   rd_data,
   output mfd_pkg::frame_bytes_type frame_bytes
);

   import mfd_pkg::*;

   localparam int BC_W  = $clog2(MAX_EDGES / 2 + 1);
   localparam int BI_W  = $clog2(FRAME_BYTES);
   localparam int CMP_W = (CNT_W > MIN_EDGES_W) ? CNT_W : MIN_EDGES_W;

   typedef enum logic [3:0] {
      D_IDLE  = 4'b0001,
      D_READ  = 4'b0010,
      D_CHECK = 4'b0100,
      D_DONE  = 4'b1000
   } dstate_type;

   dstate_type       state_ff, state_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic             dv_ff, dv_in;
   logic             dph_ff, dph_in;
   logic             dlast_ff, dlast_in;
   logic             first_ff, first_in;
   logic [7:0]       acc_ff, acc_in;
   logic [BC_W-1:0]  bc_ff, bc_in;
   status_type       status_ff, status_in;
   frame_bytes_type  bytes_ff;

   logic             byte_we;
   logic [BI_W-1:0]  byte_idx;
   logic [7:0]       byte_wd;
   logic             in_range;
   logic             is_long;
   logic             too_few;
   logic [7:0]       acc_shift;
   logic [CNT_W-1:0] pair_end;

   assign pair_end = {edge_count[CNT_W-1:1], 1'b0};
   assign too_few  = (edge_count < CNT_W'(2)) ||
                     (CMP_W'(edge_count) < CMP_W'(min_edges));
   assign is_long  = ({rd_data, 1'b0} >= sum);
   assign byte_idx = bc_ff[BI_W+2:3];
   assign in_range = (bc_ff[BC_W-1:3] < (BC_W-3)'(FRAME_BYTES));
   assign acc_shift = {acc_ff[6:0], is_long};

   always_comb begin
      state_in  = state_ff;
      issue_in  = issue_ff;
      dv_in     = 1'b0;
      dph_in    = dph_ff;
      dlast_in  = dlast_ff;
      first_in  = first_ff;
      acc_in    = acc_ff;
      bc_in     = bc_ff;
      status_in = status_ff;
      byte_we   = 1'b0;
      byte_wd   = acc_shift;
      rd_en     = 1'b0;
      rd_addr   = issue_ff[ADDR_W-1:0];
      case (state_ff)
         D_IDLE: begin
            if (ctrl.start) begin
               issue_in = '0;
               acc_in   = '0;
               bc_in    = '0;
               if (too_few) begin
                  status_in = ST_TOO_FEW;
                  state_in  = D_DONE;
               end else begin
                  state_in = D_READ;
               end
            end
         end
         D_READ: begin
            if (issue_ff < pair_end) begin
               rd_en    = 1'b1;
               issue_in = issue_ff + CNT_W'(1);
               dv_in    = 1'b1;
               dph_in   = issue_ff[0];
               dlast_in = (issue_ff == pair_end - CNT_W'(1));
            end
            if (dv_ff) begin
               if (!dph_ff) begin
                  first_in = is_long;
               end else if (first_ff == is_long) begin
                  status_in = ST_BAD_PAIR;
                  state_in  = D_DONE;
                  dv_in     = 1'b0;
               end else begin
                  bc_in = bc_ff + BC_W'(1);
                  if (bc_ff[2:0] == 3'd7) begin
                     acc_in  = '0;
                     byte_we = in_range;
                  end else begin
                     acc_in = acc_shift;
                  end
                  if (dlast_ff) begin
                     state_in = D_CHECK;
                  end
               end
            end
         end
         D_CHECK: begin
            // A partial last byte keeps its bits in the low positions.
            byte_wd = acc_ff;
            byte_we = in_range && (bc_ff[2:0] != 3'd0);
            if ((bc_ff < BC_W'(LEN_LO)) || (bc_ff > BC_W'(LEN_HI))) begin
               status_in = ST_BAD_LEN;
            end else if (bytes_ff[0] != expected_id) begin
               status_in = ST_BAD_ID;
            end else begin
               status_in = ST_OK;
            end
            state_in = D_DONE;
         end
         D_DONE: begin
            if (ctrl.ack) begin
               state_in = D_IDLE;
            end
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         dv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         dv_ff    <= dv_in;
      end
      issue_ff  <= issue_in;
      dph_ff    <= dph_in;
      dlast_ff  <= dlast_in;
      first_ff  <= first_in;
      acc_ff    <= acc_in;
      bc_ff     <= bc_in;
      status_ff <= status_in;
      if (byte_we) begin
         bytes_ff[byte_idx] <= byte_wd;
      end
   end

   assign stat.done   = (state_ff == D_DONE);
   assign stat.status = status_ff;
   assign frame_bytes = bytes_ff;

endmodule

@@ rtl/manchester_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// Manchester frame decoder
// Collects edge intervals into a store and decodes a closed frame into
// six temperatures and a relay mask.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Transaction carries
//   req_bus   in         kind, interval (one edge, or an idle timeout)
//   rsp_bus   out        status, temp_a..temp_f, relay_mask (one per frame)
//   csr_bus   in         index, data (register write)
//
// An edge transaction writes one entry of the interval store while the store
// has room. A timeout on a non-empty frame starts the decode walk, which
// reads the store through its single read port one entry a cycle. The walk
// reads the stored pairs and then checks the frame length and ID before the
// result is registered; a frame with too few edges skips the walk, and a
// broken pair ends the walk early. No transaction is taken on req_bus
// during the walk. Reset is synchronous and needs no clearing pass, since
// the store is never read beyond the fill count. A stalled result holds its
// register; edges are taken meanwhile, but the next walk then waits at its
// end until the register is free, and req_bus stays stalled until then.
//
module manchester_frame_decoder #(
   parameter int MAX_EDGES = mfd_pkg::MAX_EDGES_DEF
) (
   input logic       clock,
   input logic       reset,
   mfd_req_if.sink   req_bus,
   mfd_rsp_if.source rsp_bus,
   mfd_csr_if.sink   csr_bus
);

   import mfd_pkg::*;

   localparam int ADDR_W = $clog2(MAX_EDGES);
   localparam int CNT_W  = $clog2(MAX_EDGES + 1);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_RUN  = 2'b10
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   interval_type          shortest_ff, shortest_in;
   interval_type          longest_ff, longest_in;
   min_edges_type         min_edges_ff;
   id_type                expected_id_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff;
   temp_type              temp_ff [NUM_TEMPS];
   temp_type              temp_in [NUM_TEMPS];
   logic [NUM_RELAYS-1:0] relay_ff, relay_in;

   logic                  req_accept;
   logic                  edge_we;
   logic                  finish;
   sum_type               sum;
   dec_ctrl_type          dec_ctrl;
   dec_stat_type          dec_stat;
   logic                  rd_en;
   logic [ADDR_W-1:0]     rd_addr;
   interval_type          rd_data;
   frame_bytes_type       frame_bytes;

   // Register writes are always taken; unknown indexes are ignored.
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_edges_ff   <= MIN_EDGES_RST;
         expected_id_ff <= EXPECTED_ID_RST;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_MIN_EDGES:   min_edges_ff   <= csr_bus.data[MIN_EDGES_W-1:0];
            REG_EXPECTED_ID: expected_id_ff <= csr_bus.data[ID_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Edges are stored only while the frame collector is idle, and the walk
   // reads only while it runs, so store writes and reads never overlap.
   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign edge_we       = req_accept && (req_bus.kind == KIND_EDGE) &&
                          (count_ff < CNT_W'(MAX_EDGES));

   // The result register is free when empty or being taken this cycle.
   assign finish = (state_ff == S_RUN) && dec_stat.done &&
                   (!rsp_valid_ff || rsp_bus.ready);

   assign dec_ctrl.start = req_accept && (req_bus.kind == KIND_TIMEOUT) &&
                           (count_ff != '0);
   assign dec_ctrl.ack   = finish;
   assign sum = {1'b0, shortest_ff} + {1'b0, longest_ff};

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      shortest_in = shortest_ff;
      longest_in  = longest_ff;
      case (state_ff)
         S_IDLE: begin
            if (edge_we) begin
               count_in = count_ff + CNT_W'(1);
               if (req_bus.interval < shortest_ff) begin
                  shortest_in = req_bus.interval;
               end
               if (req_bus.interval > longest_ff) begin
                  longest_in = req_bus.interval;
               end
            end
            if (dec_ctrl.start) begin
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            // Every closed frame, good or bad, starts the next one afresh.
            if (finish) begin
               state_in    = S_IDLE;
               count_in    = '0;
               shortest_in = '1;
               longest_in  = '0;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result fields: the payload is zero unless the frame decoded cleanly.
   always_comb begin
      relay_in = '0;
      for (int k = 0; k < NUM_TEMPS; k++) begin
         temp_in[k] = '0;
         if (dec_stat.status == ST_OK) begin
            temp_in[k] = {frame_bytes[1 + 2 * k], frame_bytes[2 + 2 * k]};
         end
      end
      for (int r = 0; r < NUM_RELAYS; r++) begin
         if (dec_stat.status == ST_OK) begin
            relay_in[r] = (frame_bytes[FIRST_RELAY + r] != 8'd0);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         shortest_ff  <= '1;
         longest_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         shortest_ff  <= shortest_in;
         longest_ff   <= longest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (finish) begin
         rsp_status_ff <= dec_stat.status;
         relay_ff      <= relay_in;
         for (int k = 0; k < NUM_TEMPS; k++) begin
            temp_ff[k] <= temp_in[k];
         end
      end
   end

   mfd_ram #(
      .WIDTH (INTERVAL_W),
      .DEPTH (MAX_EDGES)
   ) u_interval_store (
      .clock   (clock),
      .wr_en   (edge_we),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_bus.interval),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mfd_decode #(
      .MAX_EDGES (MAX_EDGES)
   ) u_decode (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (dec_ctrl),
      .stat        (dec_stat),
      .edge_count  (count_ff),
      .min_edges   (min_edges_ff),
      .expected_id (expected_id_ff),
      .sum         (sum),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .frame_bytes (frame_bytes)
   );

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.temp_a     = temp_ff[0];
   assign rsp_bus.temp_b     = temp_ff[1];
   assign rsp_bus.temp_c     = temp_ff[2];
   assign rsp_bus.temp_d     = temp_ff[3];
   assign rsp_bus.temp_e     = temp_ff[4];
   assign rsp_bus.temp_f     = temp_ff[5];
   assign rsp_bus.relay_mask = relay_ff;

   // A new result only appears at the end of a decode walk.
   a_rsp_from_run: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RUN))
      else $error("result raised outside a decode walk");

   // The fill count never passes the store depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_EDGES))
      else $error("edge count beyond store depth");

   // Any stored edge leaves shortest no greater than longest.
   a_min_max: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (shortest_ff <= longest_ff))
      else $error("shortest interval above longest");

   // A failed frame never carries relay bits.
   a_err_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != ST_OK)) |-> (relay_ff == '0))
      else $error("relay bits set on a failed frame");

endmodule
